FILE: hdl/psq_pkg.sv
// shared types and constants for the pen sample qualifier
`default_nettype none

package psq_pkg;

    // sample status codes
    localparam logic [7:0] ST_PRESSED = 8'h11;
    localparam logic [7:0] ST_HOVER   = 8'h10;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_KEEP_EVERY  = 1'b0,
        CFG_HOVER_LIMIT = 1'b1
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [3:0] KEEP_EVERY_RST  = 4'd2;
    localparam logic [7:0] HOVER_LIMIT_RST = 8'd10;
    localparam logic [3:0] SKIP_MAX        = 4'hf;

    typedef struct packed {
        logic [7:0]  pen_status;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [15:0] raw_pressure;
    } t_sample;

    typedef struct packed {
        logic [14:0] point_x;
        logic [13:0] point_y;
        logic [7:0]  point_pressure;
    } t_point;

    typedef struct packed {
        logic [3:0]  skip_count;
        logic [14:0] last_x;
        logic [14:0] last_y;
        logic        stroke_open;
        logic [7:0]  hover_count;
    } t_state;

    typedef struct packed {
        logic [3:0] keep_every;
        logic [7:0] hover_limit;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hdl/psq_sample_if.sv
// request channel carrying one raw digitizer sample
`default_nettype none

interface psq_sample_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pen_status;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] raw_pressure;

    modport source (output valid, output pen_status, output raw_x, output raw_y,
                    output raw_pressure, input ready);
    modport sink   (input valid, input pen_status, input raw_x, input raw_y,
                    input raw_pressure, output ready);
endinterface

`default_nettype wire

FILE: hdl/psq_point_if.sv
// request channel carrying one qualified point record
`default_nettype none

interface psq_point_if;
    logic        valid;
    logic        ready;
    logic [14:0] point_x;
    logic [13:0] point_y;
    logic [7:0]  point_pressure;

    modport source (output valid, output point_x, output point_y,
                    output point_pressure, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input point_pressure, output ready);
endinterface

`default_nettype wire

FILE: hdl/psq_step.sv
// next-state and result logic for one qualified sample
`default_nettype none

module psq_step (
    input  var psq_pkg::t_sample i_sample,
    input  var psq_pkg::t_state  i_state,
    input  var psq_pkg::t_cfg    i_cfg,
    output var psq_pkg::t_state  o_state,
    output logic                 o_emit,
    output var psq_pkg::t_point  o_point
);
    import psq_pkg::*;

    logic [14:0] x;
    logic [14:0] y;
    logic [13:0] p;
    logic [7:0]  p_byte;
    logic        repeats;
    logic [7:0]  hover_inc;

    assign x       = i_sample.raw_x[15:1];
    assign y       = i_sample.raw_y[15:1];
    assign p       = i_sample.raw_pressure[15:2];
    assign p_byte  = (p == 14'd0) ? 8'd1 : p[7:0];
    assign repeats = ((i_state.last_x != 15'd0) || (i_state.last_y != 15'd0))
                     && (i_state.last_x == x) && (i_state.last_y == y);
    assign hover_inc = i_state.hover_count + 8'd1;

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_point = '0;
        unique case (i_sample.pen_status)
            ST_PRESSED: begin
                if (i_state.skip_count < i_cfg.keep_every) begin
                    if (i_state.skip_count != SKIP_MAX) begin
                        o_state.skip_count = i_state.skip_count + 4'd1;
                    end
                end else begin
                    o_state.skip_count = '0;
                    if (!repeats) begin
                        o_state.last_x = x;
                        o_state.last_y = y;
                        o_emit         = 1'b1;
                        if (i_state.hover_count != 8'd0) begin
                            // first press after hovering closes the old stroke
                            o_state.hover_count = '0;
                        end else begin
                            o_state.stroke_open    = 1'b1;
                            o_point.point_x        = x;
                            o_point.point_y        = y[13:0];
                            o_point.point_pressure = p_byte;
                        end
                    end
                end
            end
            ST_HOVER: begin
                if (i_state.stroke_open) begin
                    o_state.skip_count  = '0;
                    o_state.hover_count = hover_inc;
                    if (!repeats) begin
                        o_state.last_x = x;
                        o_state.last_y = y;
                        o_emit         = 1'b1;
                        if (hover_inc > i_cfg.hover_limit) begin
                            o_state.hover_count = '0;
                            o_state.stroke_open = 1'b0;
                        end else begin
                            o_point.point_x = x;
                            o_point.point_y = y[13:0];
                        end
                    end
                end
            end
            default: begin
                if (i_state.stroke_open && (i_state.hover_count != 8'd0)) begin
                    o_state.hover_count = '0;
                    o_state.stroke_open = 1'b0;
                    o_emit              = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/pen_sample_qualifier_unit.sv
// top level of the pen sample qualifier
`default_nettype none

// pen sample qualifier: takes one digitizer sample per request and gives
// zero or one point record for it. a sample is registered on acceptance,
// judged against the stroke state by a single pass of compares and shifts,
// and any resulting point lands in the output register. throughput is one
// sample per clock unless the sink holds back points; a sample passes the
// input register and then the output register before its point is offered.
// the two registers together let a new sample be taken while a finished
// point waits for the sink. lift markers come out as all-zero records.
// the user writes keep_every (index 0) and hover_limit (index 1) through
// the plain config port only while idle; the block does not enforce this.
module pen_sample_qualifier_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    psq_sample_if.sink                 i_sample,
    psq_point_if.source                o_point,
    input  logic                       i_cfg_we,
    input  psq_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [psq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psq_pkg::*;

    // config registers
    t_cfg    r_cfg;

    // input stage
    logic    r_in_valid;
    t_sample r_in;

    // stroke state
    t_state  r_state;
    t_state  n_state;

    // output stage
    logic    r_out_valid;
    t_point  r_out;

    logic    n_emit;
    t_point  n_point;
    logic    advance;
    logic    process;
    logic    in_fire;

    // the held sample moves on whenever the output register is free or drains
    assign advance = !r_out_valid || o_point.ready;
    assign process = r_in_valid && advance;
    assign i_sample.ready = !r_in_valid || advance;
    assign in_fire = i_sample.valid && i_sample.ready;

    psq_step u_step (
        .i_sample (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_emit   (n_emit),
        .o_point  (n_point)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_every  <= KEEP_EVERY_RST;
            r_cfg.hover_limit <= HOVER_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEEP_EVERY:  r_cfg.keep_every  <= i_cfg_data[3:0];
                CFG_HOVER_LIMIT: r_cfg.hover_limit <= i_cfg_data[7:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.pen_status   <= i_sample.pen_status;
            r_in.raw_x        <= i_sample.raw_x;
            r_in.raw_y        <= i_sample.raw_y;
            r_in.raw_pressure <= i_sample.raw_pressure;
        end
    end

    // stroke state commits once per processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (process) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_point.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && n_emit) begin
            r_out <= n_point;
        end
    end

    assign o_point.valid          = r_out_valid;
    assign o_point.point_x        = r_out.point_x;
    assign o_point.point_y        = r_out.point_y;
    assign o_point.point_pressure = r_out.point_pressure;

    // pending hovers only exist inside an open stroke
    a_hover_in_stroke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.hover_count != 8'd0) |-> r_state.stroke_open)
        else $error("hover count nonzero with stroke closed");

    // a pressed point leaves the stroke open
    a_press_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && n_emit && (n_point.point_pressure != 8'd0)) |=> r_state.stroke_open)
        else $error("pressed point emitted without opening stroke");

    // stroke state holds while the held sample is stalled
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> $stable(r_state))
        else $error("stroke state changed during stall");

endmodule

`default_nettype wire
